FILE: rtl/spim_pkg.sv
`default_nettype none

package spim_pkg;

	localparam int RX_DEPTH     = 8;
	localparam int SELECT_LINES = 4;
	localparam int RX_AW        = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int RX_CW        = $clog2(RX_DEPTH + 1);

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [5:0] REG_CR1    = 6'd0;
	localparam logic [5:0] REG_CR2    = 6'd1;
	localparam logic [5:0] REG_SR     = 6'd2;
	localparam logic [5:0] REG_DR     = 6'd3;
	localparam logic [5:0] REG_CSCTRL = 6'd4;

	localparam logic [7:0] CR1_MASK = 8'h44;
	localparam logic [7:0] CR2_MASK = 8'hF0;
	localparam logic [3:0] SR_W1C   = 4'hC;
	localparam logic [3:0] SR_RESET = 4'h2;

	localparam int SR_RXNE = 0;
	localparam int SR_TXE  = 1;
	localparam int SR_UDR  = 2;
	localparam int SR_OVR  = 3;

	localparam int EN_TXE  = 7;
	localparam int EN_RXNE = 6;
	localparam int EN_ERR  = 5;

	localparam logic [1:0] IRQ_NONE = 2'd0;
	localparam logic [1:0] IRQ_TXE  = 2'd1;
	localparam logic [1:0] IRQ_RXNE = 2'd2;
	localparam logic [1:0] IRQ_ERR  = 2'd3;

	typedef struct packed {
		logic push;
		logic pop;
	} rx_ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic last;
	} rx_stat_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       send_valid;
		logic [7:0] send_byte;
		logic [1:0] irq_level;
		logic [3:0] cs_n;
	} result_t;

	function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
		return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/spim_fifo.sv
`default_nettype none

module spim_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spim_pkg::rx_ctrl_t ctrl,
	input  wire logic [7:0]        push_data,
	output logic [7:0]             head_data,
	output spim_pkg::rx_stat_t     stat
);
	import spim_pkg::*;

	logic [7:0]       store_q [RX_DEPTH];
	logic [RX_AW-1:0] head_q;
	logic [RX_AW-1:0] tail_q;
	logic [RX_CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			store_q[tail_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.push) begin
				tail_q  <= rx_next(tail_q);
				count_q <= count_q + RX_CW'(1);
			end else if (ctrl.pop) begin
				head_q  <= rx_next(head_q);
				count_q <= count_q - RX_CW'(1);
			end
		end
	end

	assign head_data  = store_q[head_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == RX_CW'(RX_DEPTH));
	assign stat.last  = (count_q == RX_CW'(1));

endmodule

`default_nettype wire

FILE: rtl/spim_regs.sv
`default_nettype none

module spim_regs (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic               opcode,
	input  wire logic [5:0]         word_index,
	input  wire logic [7:0]         write_data,
	input  wire spim_pkg::rx_stat_t rx_stat,
	input  wire logic [7:0]         rx_head,
	output spim_pkg::rx_ctrl_t      rx_ctrl,
	output spim_pkg::result_t       res
);
	import spim_pkg::*;

	logic [7:0] cr1_q, cr2_q, cs_q;
	logic [3:0] sr_q;
	logic [7:0] cr1_d, cr2_d, cs_d;
	logic [3:0] sr_d;

	always_comb begin
		cr1_d          = cr1_q;
		cr2_d          = cr2_q;
		cs_d           = cs_q;
		sr_d           = sr_q;
		rx_ctrl        = '0;
		res.read_data  = '0;
		res.send_valid = 1'b0;
		res.send_byte  = '0;
		if (go) begin
			if (opcode == OP_READ) begin
				unique case (word_index)
					REG_CR1:    res.read_data = cr1_q;
					REG_CR2:    res.read_data = cr2_q;
					REG_SR:     res.read_data = {4'b0, sr_q};
					REG_CSCTRL: res.read_data = cs_q;
					REG_DR: begin
						if (!rx_stat.empty) begin
							res.read_data = rx_head;
							rx_ctrl.pop   = 1'b1;
						end else begin
							sr_d[SR_UDR] = 1'b1;
						end
						if (rx_stat.empty || rx_stat.last) begin
							sr_d[SR_RXNE] = 1'b0;
						end
					end
					default: ;
				endcase
			end else begin
				unique case (word_index)
					REG_CR1:    cr1_d = write_data & CR1_MASK;
					REG_CR2:    cr2_d = write_data & CR2_MASK;
					REG_SR:     sr_d  = sr_q & ~(write_data[3:0] & SR_W1C);
					REG_CSCTRL: cs_d  = write_data;
					REG_DR: begin
						res.send_valid = 1'b1;
						res.send_byte  = write_data;
						rx_ctrl.push   = !rx_stat.full;
						sr_d[SR_TXE]   = 1'b1;
						sr_d[SR_RXNE]  = 1'b1;
					end
					default: ;
				endcase
			end
		end

		res.irq_level = IRQ_NONE;
		if (sr_d[SR_TXE] && cr2_d[EN_TXE]) begin
			res.irq_level = IRQ_TXE;
		end
		if (sr_d[SR_RXNE] && cr2_d[EN_RXNE]) begin
			res.irq_level = IRQ_RXNE;
		end
		if ((sr_d[SR_UDR] || sr_d[SR_OVR]) && cr2_d[EN_ERR]) begin
			res.irq_level = IRQ_ERR;
		end

		res.cs_n = 4'hF;
		for (int i = 0; i < SELECT_LINES; i++) begin
			res.cs_n[i] = !(cs_d[i] && cs_d[i+4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr1_q <= '0;
			cr2_q <= '0;
			cs_q  <= '0;
			sr_q  <= SR_RESET;
		end else begin
			cr1_q <= cr1_d;
			cr2_q <= cr2_d;
			cs_q  <= cs_d;
			sr_q  <= sr_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/spi_master_register_block.sv
`default_nettype none

// SPI master register block: one register access per item, one result item per
// access, one item per clock when the result side does not stall. An item is held
// in an input register, then decoded against the register file and the 8-entry RX
// FIFO in one combinational pass and captured in the result register, which also
// updates the state; the next item is taken in the same cycle. A DR write sends
// write_data and pushes slave_reply_byte (dropped when the FIFO is full); a DR read
// pops the FIFO or, when empty, returns 0 and sets the underflow flag. irq_level
// and chip_select_n show the state after the access.
module spi_master_register_block (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       opcode,
	input  wire logic [5:0] word_index,
	input  wire logic [7:0] write_data,
	input  wire logic [7:0] slave_reply_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      read_data,
	output logic            spi_send_valid,
	output logic [7:0]      spi_send_byte,
	output logic [1:0]      irq_level,
	output logic [3:0]      chip_select_n
);
	import spim_pkg::*;

	logic       valid_s1;
	logic       opcode_s1;
	logic [5:0] word_index_s1;
	logic [7:0] write_data_s1;
	logic [7:0] reply_s1;
	logic       out_valid_q;
	result_t    res_q;
	result_t    res;
	rx_ctrl_t   rx_ctrl;
	rx_stat_t   rx_stat;
	logic [7:0] rx_head;
	logic       advance;
	logic       go;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign go       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1     <= opcode;
			word_index_s1 <= word_index;
			write_data_s1 <= write_data;
			reply_s1      <= slave_reply_byte;
		end
	end

	spim_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (rx_ctrl),
		.push_data (reply_s1),
		.head_data (rx_head),
		.stat      (rx_stat)
	);

	spim_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.opcode     (opcode_s1),
		.word_index (word_index_s1),
		.write_data (write_data_s1),
		.rx_stat    (rx_stat),
		.rx_head    (rx_head),
		.rx_ctrl    (rx_ctrl),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = res_q.read_data;
	assign spi_send_valid = res_q.send_valid;
	assign spi_send_byte  = res_q.send_byte;
	assign irq_level      = res_q.irq_level;
	assign chip_select_n  = res_q.cs_n;

endmodule

`default_nettype wire

FILE: rtl/spim_checker.sv
`default_nettype none

module spim_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] read_data,
	input wire logic       spi_send_valid,
	input wire logic [7:0] spi_send_byte,
	input wire logic [1:0] irq_level,
	input wire logic [3:0] chip_select_n
);
	import spim_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result item dropped");

	a_idle_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !spi_send_valid |-> spi_send_byte == 8'h00)
		else $error("send byte without a send");

	a_write_rd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && spi_send_valid |-> read_data == 8'h00)
		else $error("read data on a write item");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while the result side is free");

endmodule

bind spi_master_register_block spim_checker u_spim_checker (.*);

`default_nettype wire
